FILE: rtl/wildcard_byte_pattern_scan_macros.svh
// ----------------------------------------------------------------------------
// wildcard byte pattern scan assertion macros
// shared concurrent assertion wrappers for the scan block
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCAN_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_MACROS_SVH

// checked at every rising clock edge outside reset
`define WBPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every rising clock edge, reset included
`define WBPS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// types and constants shared by the wildcard byte pattern scan block
// ----------------------------------------------------------------------------
package wbps_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;
   localparam int POS_BITS       = 32;
   localparam int COUNT_BITS     = 16;
   localparam int LEN_BITS       = 5;
   localparam int ADDR_OUT_BITS  = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PATTERN_LOW   = 3'd0,
      REG_PATTERN_HIGH  = 3'd1,
      REG_WILDCARD_MASK = 3'd2,
      REG_PATTERN_LEN   = 3'd3,
      REG_OCCURRENCE    = 3'd4,
      REG_BASE_ADDRESS  = 3'd5,
      REG_RESULT_OFFSET = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [63:0]             pattern_low;
      logic [63:0]             pattern_high;
      logic [15:0]             wildcard_mask;
      logic [LEN_BITS-1:0]     pattern_length;
      logic [COUNT_BITS-1:0]   occurrence;
      logic [31:0]             base_address;
      logic signed [31:0]      result_offset;
   } cfg_type;

   typedef struct packed {
      logic                     found;
      logic [ADDR_OUT_BITS-1:0] match_address;
   } result_type;

endpackage

FILE: rtl/wbps_if.sv
// ----------------------------------------------------------------------------
// wbps channel interfaces
// valid/ready channels for bytes, results and register writes
// ----------------------------------------------------------------------------
interface wbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface wbps_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               found;
   logic [wbps_pkg::ADDR_OUT_BITS-1:0] match_address;

   modport source (output valid, output found, output match_address, input ready);
   modport sink (input valid, input found, input match_address, output ready);
endinterface

interface wbps_csr_if;
   logic                                valid;
   logic                                ready;
   logic [wbps_pkg::CSR_INDEX_BITS-1:0] index;
   logic [wbps_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/wildcard_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// streaming byte scan for a wildcard pattern, reporting the nth match address
// ----------------------------------------------------------------------------
// req_chan takes one byte per word with a last flag closing each range.
// rsp_chan returns at most one word per range: found with the address
// base + match start + offset, or found=0 and address 0 on the last byte
// when the requested match never completed. After a match the rest of the
// range is consumed silently; the last byte then clears the stream state.
// csr_chan writes registers by index (0 pattern_low .. 6 result_offset),
// always ready; write only while no byte is in flight.
// Throughput: one byte per cycle while req_chan.ready is high. The window
// shift, the parallel compare against all pattern bytes and the address
// sum finish in the accepting cycle, and the result is then registered.
// Results sit in an output register backed by one skid slot; req_chan.ready
// drops only while both slots hold words that the receiver has not taken.
// Synchronous reset clears the stream state, the output slots and the
// registers (pattern_length resets to 1); no clearing pass is needed.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan #(
   parameter int MAX_PATTERN  = 16,
   parameter int ADDRESS_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   wbps_req_if.sink    req_chan,
   wbps_rsp_if.source  rsp_chan,
   wbps_csr_if.sink    csr_chan
);

   wbps_pkg::cfg_type    cfg;
   wbps_pkg::result_type res_data;
   logic                 res_valid;
   logic                 space;
   logic                 accept;

   assign req_chan.ready = space;
   assign accept = req_chan.valid && space;

   wbps_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   wbps_scan #(
      .MAX_PATTERN  (MAX_PATTERN),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (accept),
      .data_byte (req_chan.data_byte),
      .last      (req_chan.last),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   wbps_skid u_skid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (res_valid),
      .in_data  (res_data),
      .space    (space),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: rtl/wbps_csr.sv
// ----------------------------------------------------------------------------
// wbps_csr
// configuration registers of the scan block, written over the csr channel
// ----------------------------------------------------------------------------
module wbps_csr (
   input  logic              clock,
   input  logic              reset,
   wbps_csr_if.sink          csr_chan,
   output wbps_pkg::cfg_type cfg
);

   wbps_pkg::cfg_type cfg_ff;
   wbps_pkg::cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (wbps_pkg::reg_index_type'(csr_chan.index))
            wbps_pkg::REG_PATTERN_LOW:   cfg_in.pattern_low = csr_chan.data;
            wbps_pkg::REG_PATTERN_HIGH:  cfg_in.pattern_high = csr_chan.data;
            wbps_pkg::REG_WILDCARD_MASK: cfg_in.wildcard_mask = csr_chan.data[15:0];
            wbps_pkg::REG_PATTERN_LEN:
               cfg_in.pattern_length = csr_chan.data[wbps_pkg::LEN_BITS-1:0];
            wbps_pkg::REG_OCCURRENCE:
               cfg_in.occurrence = csr_chan.data[wbps_pkg::COUNT_BITS-1:0];
            wbps_pkg::REG_BASE_ADDRESS:  cfg_in.base_address = csr_chan.data[31:0];
            wbps_pkg::REG_RESULT_OFFSET:
               cfg_in.result_offset = $signed(csr_chan.data[31:0]);
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{pattern_length: wbps_pkg::LEN_BITS'(1), default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/wbps_scan.sv
// ----------------------------------------------------------------------------
// wbps_scan
// byte window, parallel wildcard compare, match counter and address sum
// ----------------------------------------------------------------------------
`include "wildcard_byte_pattern_scan_macros.svh"

module wbps_scan #(
   parameter int MAX_PATTERN  = 16,
   parameter int ADDRESS_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wbps_pkg::cfg_type    cfg,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 last,
   output logic                 res_valid,
   output wbps_pkg::result_type res_data
);

   localparam int IDX_BITS  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int FILL_BITS = $clog2(MAX_PATTERN + 1);
   localparam int LB        = wbps_pkg::LEN_BITS;
   localparam logic [31:0] ADDR_MASK = (ADDRESS_BITS >= 32) ? {32{1'b1}}
      : 32'((64'd1 << ADDRESS_BITS) - 64'd1);

   logic [7:0]                    window_ff [MAX_PATTERN];
   logic [7:0]                    window_in [MAX_PATTERN];
   logic [wbps_pkg::POS_BITS-1:0] pos_ff;
   logic [FILL_BITS-1:0]          fill_ff;
   logic [FILL_BITS-1:0]          fill_in;
   logic [wbps_pkg::COUNT_BITS-1:0] count_ff;
   logic                          finished_ff;

   logic [LB-1:0]  len;
   logic [LB-1:0]  sel_idx [MAX_PATTERN];
   logic [127:0]   pat_bytes;
   logic           all_ok;
   logic           hit;
   logic           target;
   logic [31:0]    start;
   logic [31:0]    addr_sum;

   assign pat_bytes = {cfg.pattern_high, cfg.pattern_low};
   assign len = (cfg.pattern_length > LB'(MAX_PATTERN)) ? LB'(MAX_PATTERN)
                                                        : cfg.pattern_length;

   always_comb begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
         window_in[i] = window_ff[i + 1];
      end
      window_in[MAX_PATTERN - 1] = data_byte;
      fill_in = (fill_ff < FILL_BITS'(MAX_PATTERN)) ? fill_ff + FILL_BITS'(1) : fill_ff;
   end

   // pattern byte k lines up with window slot MAX_PATTERN - len + k
   always_comb begin
      all_ok = 1'b1;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         sel_idx[k] = '0;
         if (LB'(k) < len) begin
            sel_idx[k] = LB'(MAX_PATTERN) - len + LB'(k);
            if (!cfg.wildcard_mask[k] &&
                window_in[sel_idx[k][IDX_BITS-1:0]] != pat_bytes[8*k +: 8]) begin
               all_ok = 1'b0;
            end
         end
      end
   end

   assign hit    = !finished_ff && (len != '0) && (LB'(fill_in) >= len) && all_ok;
   assign target = hit && (count_ff == cfg.occurrence);

   assign start    = pos_ff - {{(32-LB){1'b0}}, len} + 32'd1;
   assign addr_sum = cfg.base_address + start + $unsigned(cfg.result_offset);

   always_comb begin
      res_valid = accept && (target || (last && !finished_ff));
      res_data.found = target;
      res_data.match_address = target ? (addr_sum & ADDR_MASK) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         fill_ff     <= '0;
         count_ff    <= '0;
         finished_ff <= 1'b0;
      end else if (accept) begin
         if (last) begin
            pos_ff      <= '0;
            fill_ff     <= '0;
            count_ff    <= '0;
            finished_ff <= 1'b0;
         end else if (!finished_ff) begin
            pos_ff  <= pos_ff + 32'd1;
            fill_ff <= fill_in;
            if (target) begin
               finished_ff <= 1'b1;
            end else if (hit && count_ff != '1) begin
               count_ff <= count_ff + wbps_pkg::COUNT_BITS'(1);
            end
         end
      end
   end

   // window bytes are only compared once fill covers them, so no reset
   always_ff @(posedge clock) begin
      if (accept && !last && !finished_ff) begin
         window_ff <= window_in;
      end
   end

   `WBPS_ASSERT(a_no_result_after_found, clock, reset,
      finished_ff |-> !res_valid, "result produced after the requested match")

endmodule

FILE: rtl/wbps_skid.sv
// ----------------------------------------------------------------------------
// wbps_skid
// result register plus skid slot between the scan logic and the rsp channel
// ----------------------------------------------------------------------------
`include "wildcard_byte_pattern_scan_macros.svh"

module wbps_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  wbps_pkg::result_type in_data,
   output logic                 space,
   wbps_rsp_if.source           rsp_chan
);

   logic                 main_valid_ff;
   logic                 skid_valid_ff;
   wbps_pkg::result_type main_ff;
   wbps_pkg::result_type skid_ff;
   logic                 taken;

   assign taken = main_valid_ff && rsp_chan.ready;
   assign space = !skid_valid_ff;

   assign rsp_chan.valid         = main_valid_ff;
   assign rsp_chan.found         = main_ff.found;
   assign rsp_chan.match_address = main_ff.match_address;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         priority if (taken) begin
            main_valid_ff <= skid_valid_ff || in_valid;
            skid_valid_ff <= 1'b0;
         end else if (main_valid_ff) begin
            if (in_valid) begin
               skid_valid_ff <= 1'b1;
            end
         end else begin
            main_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (taken) begin
         main_ff <= skid_valid_ff ? skid_ff : in_data;
      end else if (main_valid_ff) begin
         if (in_valid) begin
            skid_ff <= in_data;
         end
      end else begin
         main_ff <= in_data;
      end
   end

   `WBPS_ASSERT(a_skid_needs_main, clock, reset,
      skid_valid_ff |-> main_valid_ff, "skid slot full while output slot empty")
   `WBPS_ASSERT(a_no_overflow, clock, reset,
      in_valid |-> !skid_valid_ff, "result arrived with both slots full")
   `WBPS_ASSERT(a_skid_holds, clock, reset,
      (skid_valid_ff && !rsp_chan.ready) |=> (skid_valid_ff && $stable(skid_ff)),
      "stalled skid result lost or changed")

endmodule

FILE: dv/tb_wildcard_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// tb_wildcard_byte_pattern_scan
// Self-checking bench for the wildcard byte pattern scan. Byte ranges are
// driven on req_chan with random gaps. The results on rsp_chan are taken
// under random stalls and compared against an in-bench model of the window
// compare, the match counter and the address sum. The registers go through
// their extremes in directed tests, then through random settings.
// ----------------------------------------------------------------------------
module tb_wildcard_byte_pattern_scan;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [7:0] byte_q_type[$];

   localparam int WINDOW_BYTES = 16;
   localparam int IDLE_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wbps_req_if req_bus ();
   wbps_rsp_if rsp_bus ();
   wbps_csr_if csr_bus ();

   wildcard_byte_pattern_scan dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow of the registers and the stream state
   wbps_pkg::cfg_type scan_cfg;
   logic [7:0]  scan_window [WINDOW_BYTES];
   logic [31:0] scan_pos;
   int unsigned scan_fill;
   logic [15:0] hit_count;
   logic        scan_done;

   wbps_pkg::result_type expected_results[$];
   int unsigned mismatch_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned req_gap_max = 14;
   int unsigned rsp_stall_max = 14;

   function automatic void clear_scan();
      foreach (scan_window[i]) scan_window[i] = 8'h00;
      scan_pos  = '0;
      scan_fill = 0;
      hit_count = '0;
      scan_done = 1'b0;
   endfunction

   function automatic logic [7:0] pattern_byte(input int unsigned k);
      logic [127:0] all_bytes;
      all_bytes = {scan_cfg.pattern_high, scan_cfg.pattern_low};
      return all_bytes[8*k +: 8];
   endfunction

   function automatic int unsigned active_length();
      return (scan_cfg.pattern_length > WINDOW_BYTES) ? WINDOW_BYTES
                                                      : scan_cfg.pattern_length;
   endfunction

   // advance the shadow scan by one byte, queue any result it gives
   function automatic void scan_byte(input logic [7:0] value, input logic is_last);
      int unsigned len;
      logic        hit;
      logic [31:0] start;
      wbps_pkg::result_type res;
      len = active_length();
      if (!scan_done) begin
         for (int i = 0; i < WINDOW_BYTES - 1; i++) scan_window[i] = scan_window[i+1];
         scan_window[WINDOW_BYTES-1] = value;
         if (scan_fill < WINDOW_BYTES) scan_fill++;
         hit = (len != 0) && (scan_fill >= len);
         for (int k = 0; k < len; k++) begin
            if (!scan_cfg.wildcard_mask[k] &&
                scan_window[WINDOW_BYTES-len+k] != pattern_byte(k)) hit = 1'b0;
         end
         if (hit) begin
            if (hit_count == scan_cfg.occurrence) begin
               start = scan_pos - len + 1;
               res.found = 1'b1;
               res.match_address = scan_cfg.base_address + start + scan_cfg.result_offset;
               expected_results.push_back(res);
               scan_done = 1'b1;
            end else if (hit_count != 16'hFFFF) begin
               hit_count++;
            end
         end
         scan_pos++;
      end
      if (is_last) begin
         if (!scan_done) begin
            res.found = 1'b0;
            res.match_address = '0;
            expected_results.push_back(res);
         end
         clear_scan();
      end
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic is_last);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= value;
      req_bus.last      <= is_last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      scan_byte(value, is_last);
      bytes_sent++;
   endtask

   task automatic send_range(input byte_q_type seq);
      foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
   endtask

   task automatic csr_write(input wbps_pkg::reg_index_type idx, input logic [63:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         wbps_pkg::REG_PATTERN_LOW:   scan_cfg.pattern_low    = value;
         wbps_pkg::REG_PATTERN_HIGH:  scan_cfg.pattern_high   = value;
         wbps_pkg::REG_WILDCARD_MASK: scan_cfg.wildcard_mask  = value[15:0];
         wbps_pkg::REG_PATTERN_LEN:
            scan_cfg.pattern_length = value[wbps_pkg::LEN_BITS-1:0];
         wbps_pkg::REG_OCCURRENCE:
            scan_cfg.occurrence = value[wbps_pkg::COUNT_BITS-1:0];
         wbps_pkg::REG_BASE_ADDRESS:  scan_cfg.base_address   = value[31:0];
         wbps_pkg::REG_RESULT_OFFSET: scan_cfg.result_offset  = value[31:0];
         default: ;
      endcase
   endtask

   task automatic write_config(input wbps_pkg::cfg_type c);
      csr_write(wbps_pkg::REG_PATTERN_LOW,   c.pattern_low);
      csr_write(wbps_pkg::REG_PATTERN_HIGH,  c.pattern_high);
      csr_write(wbps_pkg::REG_WILDCARD_MASK, {48'h0, c.wildcard_mask});
      csr_write(wbps_pkg::REG_PATTERN_LEN,   {59'h0, c.pattern_length});
      csr_write(wbps_pkg::REG_OCCURRENCE,    {48'h0, c.occurrence});
      csr_write(wbps_pkg::REG_BASE_ADDRESS,  {32'h0, c.base_address});
      csr_write(wbps_pkg::REG_RESULT_OFFSET, {32'h0, c.result_offset});
      csr_bus.valid <= 1'b0;
   endtask

   // sender holds off until every result is back, then lets the pipe settle
   task automatic wait_results_idle();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // directed tests
   // ---------------------------------------------------------------------
   task automatic test_reset_defaults();
      // one-byte pattern 00 after reset
      send_range('{8'h05, 8'h00, 8'hFF});
      send_range('{8'hFF});
      send_range('{8'h00});
      wait_results_idle();
   endtask

   task automatic test_full_length_wrap();
      wbps_pkg::cfg_type c;
      byte_q_type seq;
      c = '{pattern_low: 64'hF0E1D2C3B4A59687, pattern_high: 64'h78695A4B3C2D1E0F,
            wildcard_mask: 16'h8001, pattern_length: 5'd31, occurrence: 16'd0,
            base_address: 32'hFFFF_FFFF, result_offset: 32'sh7FFF_FFFF};
      write_config(c);
      // length above the window clamps to 16; match completes on the last byte
      for (int k = 0; k < WINDOW_BYTES; k++) seq.push_back(pattern_byte(k));
      seq[0]  = 8'h00;
      seq[15] = 8'hFF;
      send_range(seq);
      wait_results_idle();
   endtask

   task automatic test_short_and_zero_length();
      wbps_pkg::cfg_type c;
      c = scan_cfg;
      c.pattern_length = 5'd16;
      c.wildcard_mask  = 16'hFFFF;
      write_config(c);
      send_range('{8'h00, 8'hFF, 8'h80});
      wait_results_idle();
      c.pattern_length = 5'd0;
      write_config(c);
      send_range('{8'h00, 8'h01});
      wait_results_idle();
   endtask

   task automatic test_overlap_occurrence();
      wbps_pkg::cfg_type c;
      c = '{pattern_low: 64'h0000_0000_0000_AAAA, pattern_high: 64'h0,
            wildcard_mask: 16'h0000, pattern_length: 5'd2, occurrence: 16'd1,
            base_address: 32'h0000_0100, result_offset: 32'sh8000_0000};
      write_config(c);
      // overlapping matches at 0 and 1; the rest of the range is dropped
      send_range('{8'hAA, 8'hAA, 8'hAA, 8'h00});
      wait_results_idle();
      c.occurrence = 16'hFFFF;
      write_config(c);
      send_range('{8'hAA, 8'hAA, 8'hAA});
      wait_results_idle();
   endtask

   // ---------------------------------------------------------------------
   // random settings and ranges
   // ---------------------------------------------------------------------
   function automatic wbps_pkg::cfg_type random_config();
      wbps_pkg::cfg_type c;
      c.pattern_low  = {$urandom, $urandom};
      c.pattern_high = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0:       c.wildcard_mask = 16'h0000;
         1:       c.wildcard_mask = 16'hFFFF;
         default: c.wildcard_mask = 16'($urandom & $urandom);
      endcase
      case ($urandom_range(0, 9))
         0:       c.pattern_length = 5'd0;
         1:       c.pattern_length = 5'd16;
         2:       c.pattern_length = 5'($urandom_range(17, 31));
         3:       c.pattern_length = 5'($urandom_range(7, 15));
         default: c.pattern_length = 5'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 7))
         0:       c.occurrence = 16'hFFFF;
         1:       c.occurrence = 16'($urandom);
         default: c.occurrence = 16'($urandom_range(0, 3));
      endcase
      case ($urandom_range(0, 5))
         0:       c.base_address = 32'h0;
         1:       c.base_address = 32'hFFFF_FFFF;
         default: c.base_address = $urandom;
      endcase
      case ($urandom_range(0, 6))
         0:       c.result_offset = 32'sh0;
         1:       c.result_offset = 32'sh7FFF_FFFF;
         2:       c.result_offset = 32'sh8000_0000;
         3:       c.result_offset = -32'sd1 * $urandom_range(1, 64);
         default: c.result_offset = $urandom;
      endcase
      return c;
   endfunction

   // random bytes with copies of the pattern planted, some of them broken
   function automatic byte_q_type random_range();
      byte_q_type  seq;
      int unsigned len;
      int unsigned n;
      int unsigned s;
      int unsigned k;
      int unsigned plants;
      len = active_length();
      case ($urandom_range(0, 7))
         0:       n = 1;
         1:       n = $urandom_range(25, 48);
         default: n = $urandom_range(2, 20);
      endcase
      for (int i = 0; i < n; i++) seq.push_back(8'($urandom));
      plants = (len == 0 || len > n) ? 0 : $urandom_range(0, 3);
      repeat (plants) begin
         s = $urandom_range(0, n - len);
         for (k = 0; k < len; k++)
            if (!scan_cfg.wildcard_mask[k]) seq[s+k] = pattern_byte(k);
         if ($urandom_range(0, 4) == 0) begin
            k = $urandom_range(0, len - 1);
            seq[s+k] = ~seq[s+k];
         end
      end
      return seq;
   endfunction

   task automatic test_random_ranges();
      int unsigned goal;
      goal = bytes_sent + 700;
      while (bytes_sent < goal) begin
         case ($urandom_range(0, 3))
            0: begin req_gap_max = 0;  rsp_stall_max = 0;  end
            1: begin req_gap_max = 14; rsp_stall_max = 0;  end
            2: begin req_gap_max = 0;  rsp_stall_max = 14; end
            default: begin req_gap_max = 14; rsp_stall_max = 14; end
         endcase
         write_config(random_config());
         repeat ($urandom_range(3, 8)) send_range(random_range());
         wait_results_idle();
      end
   endtask

   // ---------------------------------------------------------------------
   // result checker: random ready stalls, compare against the oldest entry
   // ---------------------------------------------------------------------
   initial begin : result_checker
      wbps_pkg::result_type want;
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         if (expected_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result found=%b match_address=%h", $time,
                     rsp_bus.found, rsp_bus.match_address);
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.found !== want.found) begin
               mismatch_count++;
               $display("%0t: found expected %b actual %b", $time, want.found,
                        rsp_bus.found);
            end
            if (rsp_bus.match_address !== want.match_address) begin
               mismatch_count++;
               $display("%0t: match_address expected %h actual %h", $time,
                        want.match_address, rsp_bus.match_address);
            end
         end
      end
   end

   // watchdog: ends the run when no word moves for too long
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout after %0d idle cycles", IDLE_LIMIT);
      $display("FAIL wildcard_byte_pattern_scan");
      $finish;
   end

   initial begin : main_sequence
      scan_cfg = '{pattern_low: 64'h0, pattern_high: 64'h0, wildcard_mask: 16'h0,
                   pattern_length: 5'd1, occurrence: 16'd0, base_address: 32'h0,
                   result_offset: 32'sh0};
      clear_scan();
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= 8'h00;
      req_bus.last      <= 1'b0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= wbps_pkg::REG_PATTERN_LOW;
      csr_bus.data      <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_full_length_wrap();
      test_short_and_zero_length();
      test_overlap_occurrence();
      test_random_ranges();
      wait_results_idle();

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("PASS wildcard_byte_pattern_scan");
      end else begin
         $display("FAIL wildcard_byte_pattern_scan");
      end
      $finish;
   end

endmodule
